/* rtl/lif_pkg.sv */
// lif_pkg: shared constants, codes and types of the line intersection finder
// no dependencies; compiled before the interfaces and all modules

package lif_pkg;

  // default module parameters
  localparam int DEF_MAX_EDGES  = 64;
  localparam int DEF_COORD_BITS = 16;

  // fixed field widths
  localparam int SLOT_W     = 6;
  localparam int CROSS_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int EDGES_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CNT_W      = 7;
  localparam int STEP_W     = $clog2(CROSS_W + 1);

  // limits and reset values
  localparam logic [SIZE_W-1:0]  SIZE_CAP    = 13'd4096;
  localparam logic [CNT_W-1:0]   MAX_RESULTS = 7'd64;
  localparam logic [SIZE_W-1:0]  RST_WIDTH   = 13'd1024;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT  = 13'd1024;
  localparam logic [EDGES_W-1:0] RST_EDGES   = 7'd0;

  // input operation codes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } lif_opcode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_EDGES  = 2'd2
  } lif_cfg_idx_t;

  // multiply steps of one line pair, in issue order
  typedef enum logic [3:0] {
    MUL_C1A,
    MUL_C1B,
    MUL_C2A,
    MUL_C2B,
    MUL_DETA,
    MUL_DETB,
    MUL_NXA,
    MUL_NXB,
    MUL_NYA,
    MUL_NYB
  } lif_mul_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_MUL,
    ST_FIN,
    ST_XSTART,
    ST_XWAIT,
    ST_YSTART,
    ST_YWAIT,
    ST_KEEP,
    ST_NEXT,
    ST_DONE
  } lif_state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic               done;
    logic               reject;
    logic [CROSS_W-1:0] quo;
  } lif_div_res_t;

endpackage

/* rtl/lif_intf.sv */
// lif_intf: valid/ready channel interfaces of the line intersection finder
// depends on lif_pkg for field widths

interface lif_in_if #(
  parameter int COORD_BITS = lif_pkg::DEF_COORD_BITS
);
  import lif_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [SLOT_W-1:0]            edge_slot;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, operation, edge_slot, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, operation, edge_slot, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface lif_out_if;
  import lif_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  other_slot;
  logic [CROSS_W-1:0] cross_x;
  logic [CROSS_W-1:0] cross_y;
  logic               last;

  modport source (
    output valid, hit, other_slot, cross_x, cross_y, last,
    input  ready
  );
  modport sink (
    input  valid, hit, other_slot, cross_x, cross_y, last,
    output ready
  );
endinterface

interface lif_cfg_if;
  import lif_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* rtl/lif_div.sv */
// lif_div: bounded restoring divider, one quotient bit per cycle
// depends on lif_pkg; quotient is checked against 0 <= q < limit

module lif_div #(
  parameter int COORD_BITS = lif_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [3*COORD_BITS+3:0] num,
  input  logic signed [2*COORD_BITS+2:0] den,
  input  logic [lif_pkg::SIZE_W-1:0]     limit,
  output lif_pkg::lif_div_res_t          res
);
  import lif_pkg::*;

  localparam int NUM_W = 3*COORD_BITS + 4;
  localparam int DET_W = 2*COORD_BITS + 3;
  localparam int MAG_W = 3*COORD_BITS + 2;
  localparam int DM_W  = 2*COORD_BITS + 2;
  localparam int REM_W = (MAG_W > DM_W + CROSS_W) ? MAG_W : DM_W + CROSS_W;

  logic [NUM_W-1:0]   num_abs;
  logic [DET_W-1:0]   den_abs;
  logic [REM_W-1:0]   rem_r;
  logic [REM_W-1:0]   dsh_r;
  logic [STEP_W-1:0]  step_r;
  logic [CROSS_W-1:0] quo_r;
  logic [SIZE_W-1:0]  lim_r;
  logic               over_r;
  logic               neg_r;
  logic               busy_r;
  logic               done_r;
  logic               ge;

  // operand magnitudes
  assign num_abs = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
  assign den_abs = den[DET_W-1] ? $unsigned(-den) : $unsigned(den);

  // one trial subtract per cycle
  assign ge = (rem_r >= dsh_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: top step only detects a quotient of 4096 or more
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= REM_W'(MAG_W'(num_abs));
      dsh_r  <= REM_W'(DM_W'(den_abs)) << CROSS_W;
      step_r <= STEP_W'(CROSS_W);
      neg_r  <= num[NUM_W-1] ^ den[DET_W-1];
      lim_r  <= limit;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(CROSS_W)) begin
        over_r <= ge;
      end else begin
        quo_r <= {quo_r[CROSS_W-2:0], ge};
      end
    end
  end

  // status: reject negative, too large or out of window
  assign res.done   = done_r;
  assign res.quo    = quo_r;
  assign res.reject = over_r | (neg_r & (|quo_r)) | ({1'b0, quo_r} >= lim_r);

endmodule

/* rtl/line_intersection_finder.sv */
// line_intersection_finder: line table and query sequencer around one shared
// multiplier and the lif_div divider; depends on lif_pkg, lif_intf, lif_div
//
//   channel  dir  handshake      contents
//   in_ch    in   valid/ready    operation, edge_slot, start/end x/y
//   out_ch   out  valid/ready    hit, other_slot, cross_x, cross_y, last
//   cfg_ch   in   valid/ready    index, data (width, height, edges in use)
//
// a load is written to the table as it is taken, back to back while idle; a
// query reads each line in use, skips one equal to the query, else runs the
// shared multiplier steps and, for non-parallel lines, the serial divider
// the input is not ready while a query runs; a stalled output stalls the scan
// synchronous active-low reset clears control and config; table needs no reset

module line_intersection_finder #(
  parameter int MAX_EDGES  = lif_pkg::DEF_MAX_EDGES,
  parameter int COORD_BITS = lif_pkg::DEF_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  lif_in_if.sink    in_ch,
  lif_out_if.source out_ch,
  lif_cfg_if.sink   cfg_ch
);
  import lif_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int IDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SCAN_W = $clog2(MAX_EDGES + 1);
  localparam int AW     = C + 1;
  localparam int CW     = 2*C + 2;
  localparam int DET_W  = 2*C + 3;
  localparam int PW     = 3*C + 3;
  localparam int NUM_W  = 3*C + 4;
  localparam int ENT_W  = 4*C;

  lif_state_t state_r, state_nxt;

  // config registers
  logic [SIZE_W-1:0]  width_r, height_r;
  logic [EDGES_W-1:0] edges_r;
  logic [SIZE_W-1:0]  w_sat, h_sat;
  logic [SCAN_W-1:0]  n_sat;

  // table and query
  logic [ENT_W-1:0]   edge_mem [MAX_EDGES];
  logic [ENT_W-1:0]   rd_r;
  logic [ENT_W-1:0]   q_ent_r;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_en;
  logic signed [C-1:0] qx0, qy0, ex0, ey0, ex1, ey1;

  // scan control
  logic [SCAN_W-1:0]  idx_r, n_r, idx_inc;
  logic [CNT_W-1:0]   cnt_r;

  // arithmetic
  logic signed [AW-1:0]    a1_r, b1_r, a2_r, b2_r;
  logic signed [CW-1:0]    c1_r, c2_r;
  logic signed [DET_W-1:0] det_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic signed [AW-1:0]    mul_a;
  logic signed [CW-1:0]    mul_b;
  logic signed [PW-1:0]    prod_r;
  lif_mul_t                op_r, pend_op_r;
  logic                    pend_vld_r;

  // divider
  logic                    div_start;
  logic                    div_sel_y;
  logic signed [NUM_W-1:0] div_num;
  logic [SIZE_W-1:0]       div_lim;
  lif_div_res_t            div_res;

  // point, held hit and output stage
  logic [CROSS_W-1:0] px_r, py_r;
  logic               hold_vld_r;
  logic [SLOT_W-1:0]  hold_slot_r;
  logic [CROSS_W-1:0] hold_x_r, hold_y_r;
  logic               out_vld_r, out_hit_r, out_last_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [CROSS_W-1:0] out_x_r, out_y_r;
  logic               out_free;

  // fsm outputs
  logic in_rdy;
  logic in_xfer;
  logic keep_go;
  logic done_go;

  // saturated limits
  always_comb begin
    w_sat = (width_r > SIZE_CAP) ? SIZE_CAP : width_r;
    h_sat = (height_r > SIZE_CAP) ? SIZE_CAP : height_r;
    if (int'(edges_r) >= MAX_EDGES) begin
      n_sat = SCAN_W'(MAX_EDGES);
    end else begin
      n_sat = SCAN_W'(edges_r);
    end
  end

  // configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      edges_r  <= RST_EDGES;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_WIDTH:  width_r  <= cfg_ch.data;
        CFG_HEIGHT: height_r <= cfg_ch.data;
        CFG_EDGES:  edges_r  <= cfg_ch.data[EDGES_W-1:0];
        default: ;
      endcase
    end
  end

  // line table
  assign in_xfer = in_ch.valid & in_rdy;
  assign wr_idx  = IDX_W'(in_ch.edge_slot);
  assign wr_en   = in_xfer && (in_ch.operation == OP_LOAD)
                   && (int'(in_ch.edge_slot) < MAX_EDGES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_mem[wr_idx] <= {in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y};
    end
    if (state_r == ST_READ) begin
      rd_r <= edge_mem[idx_r[IDX_W-1:0]];
    end
  end

  assign qx0 = q_ent_r[4*C-1 -: C];
  assign qy0 = q_ent_r[3*C-1 -: C];
  assign ex0 = rd_r[4*C-1 -: C];
  assign ey0 = rd_r[3*C-1 -: C];
  assign ex1 = rd_r[2*C-1 -: C];
  assign ey1 = rd_r[C-1 -: C];

  assign idx_inc  = idx_r + SCAN_W'(1);
  assign out_free = !out_vld_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_ch.operation == OP_QUERY) begin
          state_nxt = (n_sat == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_PREP;
      ST_PREP: state_nxt = (rd_r == q_ent_r) ? ST_NEXT : ST_MUL;
      ST_MUL: begin
        if (op_r == MUL_NYB) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (det_r != '0) begin
          state_nxt = ST_XSTART;
        end else if (w_sat != '0 && h_sat != '0) begin
          state_nxt = ST_KEEP;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_XSTART: state_nxt = ST_XWAIT;
      ST_XWAIT: begin
        if (div_res.done) begin
          state_nxt = div_res.reject ? ST_NEXT : ST_YSTART;
        end
      end
      ST_YSTART: state_nxt = ST_YWAIT;
      ST_YWAIT: begin
        if (div_res.done) begin
          state_nxt = div_res.reject ? ST_NEXT : ST_KEEP;
        end
      end
      ST_KEEP: begin
        if (keep_go) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (idx_inc >= n_r || cnt_r == MAX_RESULTS) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_rdy    = 1'b0;
    div_start = 1'b0;
    div_sel_y = 1'b0;
    keep_go   = 1'b0;
    done_go   = 1'b0;
    case (state_r)
      ST_IDLE:   in_rdy = 1'b1;
      ST_XSTART: div_start = 1'b1;
      ST_YSTART: begin
        div_start = 1'b1;
        div_sel_y = 1'b1;
      end
      ST_KEEP:   keep_go = !hold_vld_r || out_free;
      ST_DONE:   done_go = out_free;
      default: ;
    endcase
  end

  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // query capture and scan index
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.operation == OP_QUERY) begin
      q_ent_r <= {in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y};
      a1_r    <= AW'(in_ch.end_y) - AW'(in_ch.start_y);
      b1_r    <= AW'(in_ch.start_x) - AW'(in_ch.end_x);
      n_r     <= n_sat;
      idx_r   <= '0;
      cnt_r   <= '0;
    end
    if (state_r == ST_NEXT) begin
      idx_r <= idx_inc;
    end
    if (state_r == ST_KEEP && keep_go) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (state_r == ST_PREP) begin
      a2_r <= AW'(ey1) - AW'(ey0);
      b2_r <= AW'(ex0) - AW'(ex1);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = a1_r;
    mul_b = CW'(qx0);
    case (op_r)
      MUL_C1A: begin
        mul_a = a1_r;
        mul_b = CW'(qx0);
      end
      MUL_C1B: begin
        mul_a = b1_r;
        mul_b = CW'(qy0);
      end
      MUL_C2A: begin
        mul_a = a2_r;
        mul_b = CW'(ex0);
      end
      MUL_C2B: begin
        mul_a = b2_r;
        mul_b = CW'(ey0);
      end
      MUL_DETA: begin
        mul_a = a1_r;
        mul_b = CW'(b2_r);
      end
      MUL_DETB: begin
        mul_a = a2_r;
        mul_b = CW'(b1_r);
      end
      MUL_NXA: begin
        mul_a = b2_r;
        mul_b = c1_r;
      end
      MUL_NXB: begin
        mul_a = b1_r;
        mul_b = c2_r;
      end
      MUL_NYA: begin
        mul_a = a1_r;
        mul_b = c2_r;
      end
      MUL_NYB: begin
        mul_a = a2_r;
        mul_b = c1_r;
      end
      default: ;
    endcase
  end

  // multiply issue, one step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= (state_r == ST_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      op_r <= MUL_C1A;
    end else if (state_r == ST_MUL) begin
      prod_r    <= mul_a * mul_b;
      pend_op_r <= op_r;
      op_r      <= lif_mul_t'(op_r + 4'd1);
    end
  end

  // accumulate the registered product into its term
  always_ff @(posedge clk) begin
    if (pend_vld_r) begin
      case (pend_op_r)
        MUL_C1A:  c1_r  <= CW'(prod_r);
        MUL_C1B:  c1_r  <= c1_r + CW'(prod_r);
        MUL_C2A:  c2_r  <= CW'(prod_r);
        MUL_C2B:  c2_r  <= c2_r + CW'(prod_r);
        MUL_DETA: det_r <= DET_W'(prod_r);
        MUL_DETB: det_r <= det_r - DET_W'(prod_r);
        MUL_NXA:  nx_r  <= NUM_W'(prod_r);
        MUL_NXB:  nx_r  <= nx_r - NUM_W'(prod_r);
        MUL_NYA:  ny_r  <= NUM_W'(prod_r);
        MUL_NYB:  ny_r  <= ny_r - NUM_W'(prod_r);
        default: ;
      endcase
    end
  end

  // shared divider
  assign div_num = div_sel_y ? ny_r : nx_r;
  assign div_lim = div_sel_y ? h_sat : w_sat;

  lif_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_r),
    .limit (div_lim),
    .res   (div_res)
  );

  // intersection point; parallel lines land on the origin
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      px_r <= '0;
      py_r <= '0;
    end
    if (state_r == ST_XWAIT && div_res.done) begin
      px_r <= div_res.quo;
    end
    if (state_r == ST_YWAIT && div_res.done) begin
      py_r <= div_res.quo;
    end
  end

  // one hit is held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (state_r == ST_KEEP && keep_go) begin
      hold_vld_r <= 1'b1;
    end else if (state_r == ST_DONE && done_go) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_KEEP && keep_go) begin
      hold_slot_r <= SLOT_W'(idx_r);
      hold_x_r    <= px_r;
      hold_y_r    <= py_r;
    end
  end

  // output register and transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == ST_KEEP && keep_go && hold_vld_r)
                 || (state_r == ST_DONE && done_go)) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_KEEP && keep_go && hold_vld_r) begin
      out_hit_r  <= 1'b1;
      out_slot_r <= hold_slot_r;
      out_x_r    <= hold_x_r;
      out_y_r    <= hold_y_r;
      out_last_r <= 1'b0;
    end else if (state_r == ST_DONE && done_go) begin
      out_hit_r  <= hold_vld_r;
      out_slot_r <= hold_vld_r ? hold_slot_r : '0;
      out_x_r    <= hold_vld_r ? hold_x_r : '0;
      out_y_r    <= hold_vld_r ? hold_y_r : '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.other_slot = out_slot_r;
  assign out_ch.cross_x    = out_x_r;
  assign out_ch.cross_y    = out_y_r;
  assign out_ch.last       = out_last_r;

endmodule
